### rtl/core/update_lifecycle_fsm_assert.svh
// Assertion macros for the update lifecycle sequencer.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef UPDATE_LIFECYCLE_FSM_ASSERT_SVH
`define UPDATE_LIFECYCLE_FSM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ULF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("update lifecycle assertion failed");

// Next-cycle implication, disabled during reset.
`define ULF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("update lifecycle assertion failed");

`endif

### rtl/core/ulf_pkg.sv
// Shared types and codes of the update lifecycle sequencer.
// No dependencies; every other file but the assertion header imports it.
package ulf_pkg;

    localparam int APB_AW = 4;

    typedef logic [3:0]  evt_code_t;
    typedef logic [3:0]  lc_state_t;
    typedef logic [1:0]  status_t;
    typedef logic [31:0] count_t;
    typedef logic [1:0]  reg_idx_t;

    localparam evt_code_t EV_START     = 4'd0;
    localparam evt_code_t EV_DL_OK     = 4'd1;
    localparam evt_code_t EV_DL_FAIL   = 4'd2;
    localparam evt_code_t EV_VER_OK    = 4'd3;
    localparam evt_code_t EV_VER_FAIL  = 4'd4;
    localparam evt_code_t EV_STAGE_OK  = 4'd5;
    localparam evt_code_t EV_PRE_OK    = 4'd6;
    localparam evt_code_t EV_PRE_FAIL  = 4'd7;
    localparam evt_code_t EV_ACT_OK    = 4'd8;
    localparam evt_code_t EV_ACT_FAIL  = 4'd9;
    localparam evt_code_t EV_HL_OK     = 4'd10;
    localparam evt_code_t EV_HL_FAIL   = 4'd11;
    localparam evt_code_t EV_COMMIT_OK = 4'd12;
    localparam evt_code_t EV_RB_DONE   = 4'd13;
    localparam evt_code_t EV_CANCEL    = 4'd14;

    localparam lc_state_t ST_IDLE      = 4'd0;
    localparam lc_state_t ST_DOWNLOAD  = 4'd1;
    localparam lc_state_t ST_VERIFY    = 4'd2;
    localparam lc_state_t ST_STAGE     = 4'd3;
    localparam lc_state_t ST_PREFLIGHT = 4'd4;
    localparam lc_state_t ST_ACTIVATE  = 4'd5;
    localparam lc_state_t ST_HEALTH    = 4'd6;
    localparam lc_state_t ST_COMMIT    = 4'd7;
    localparam lc_state_t ST_DONE      = 4'd8;
    localparam lc_state_t ST_ROLLBACK  = 4'd9;
    localparam lc_state_t ST_FAILED    = 4'd10;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_REJECTED = 2'd1;
    localparam status_t STATUS_HOOKFAIL = 2'd2;

    localparam reg_idx_t REG_ACTIVATE_HOOK = 2'd0;
    localparam reg_idx_t REG_COMMIT_HOOK   = 2'd1;
    localparam reg_idx_t REG_ROLLBACK_HOOK = 2'd2;

    typedef struct packed {
        logic activate;
        logic commit;
        logic rollback;
    } hook_cfg_t;

    typedef struct packed {
        logic seq;
        logic started;
        logic committed;
        logic rollback;
        logic verify_fail;
        logic health_fail;
        logic rejected;
        logic cancel;
    } cnt_inc_t;

    typedef struct packed {
        status_t   status;
        lc_state_t next_state;
        cnt_inc_t  inc;
    } step_t;

    typedef struct packed {
        lc_state_t cur_state;
        count_t    seq;
        count_t    started;
        count_t    committed;
        count_t    rollback;
        count_t    verify_fail;
        count_t    health_fail;
        count_t    rejected;
        count_t    cancel;
    } snap_t;

endpackage

### rtl/core/ulf_evt_if.sv
// Event request channel of the update lifecycle sequencer.
// Depends on ulf_pkg.
interface ulf_evt_if;
    import ulf_pkg::*;

    logic      valid;
    logic      ready;
    evt_code_t event_code;
    logic      hook_failed;

    modport source (output valid, output event_code, output hook_failed, input ready);
    modport sink   (input valid, input event_code, input hook_failed, output ready);
endinterface

### rtl/core/ulf_res_if.sv
// Result channel of the update lifecycle sequencer.
// Depends on ulf_pkg.
interface ulf_res_if;
    import ulf_pkg::*;

    logic      valid;
    logic      ready;
    status_t   status;
    lc_state_t cur_state;
    count_t    seq_count;
    count_t    started_count;
    count_t    committed_count;
    count_t    rollback_count;
    count_t    verify_fail_count;
    count_t    health_fail_count;
    count_t    rejected_count;
    count_t    cancel_count;

    modport source (
        output valid, output status, output cur_state, output seq_count,
        output started_count, output committed_count, output rollback_count,
        output verify_fail_count, output health_fail_count, output rejected_count,
        output cancel_count, input ready
    );
    modport sink (
        input valid, input status, input cur_state, input seq_count,
        input started_count, input committed_count, input rollback_count,
        input verify_fail_count, input health_fail_count, input rejected_count,
        input cancel_count, output ready
    );
endinterface

### rtl/core/ulf_apb.sv
// APB register block holding the three hook enables.
// Depends on ulf_pkg.
module ulf_apb (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ulf_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ulf_pkg::hook_cfg_t          hooks
);
    import ulf_pkg::*;

    hook_cfg_t hooks_reg;
    hook_cfg_t hooks_next;
    reg_idx_t  idx;
    logic      wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        hooks_next = hooks_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ACTIVATE_HOOK: hooks_next.activate = pwdata[0];
                REG_COMMIT_HOOK:   hooks_next.commit   = pwdata[0];
                REG_ROLLBACK_HOOK: hooks_next.rollback = pwdata[0];
                default:           hooks_next = hooks_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ACTIVATE_HOOK: prdata = {31'd0, hooks_reg.activate};
            REG_COMMIT_HOOK:   prdata = {31'd0, hooks_reg.commit};
            REG_ROLLBACK_HOOK: prdata = {31'd0, hooks_reg.rollback};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hooks_reg <= '0;
        end
        else
        begin
            hooks_reg <= hooks_next;
        end
    end

    assign hooks = hooks_reg;
endmodule

### rtl/core/ulf_step.sv
// Transition logic: decides the next state, the status and which counters move.
// Depends on ulf_pkg.
module ulf_step (
    input  ulf_pkg::lc_state_t  cur_state,
    input  ulf_pkg::evt_code_t  event_code,
    input  logic                hook_failed,
    input  ulf_pkg::hook_cfg_t  hooks,
    output ulf_pkg::step_t      step
);
    import ulf_pkg::*;

    always_comb
    begin
        logic      ok;
        logic      hf;
        lc_state_t nxt;
        cnt_inc_t  inc;

        ok  = 1'b0;
        hf  = 1'b0;
        nxt = cur_state;
        inc = '0;

        case (event_code)
            EV_START:
                if (cur_state == ST_IDLE || cur_state == ST_DONE || cur_state == ST_FAILED)
                begin
                    ok = 1'b1;
                    nxt = ST_DOWNLOAD;
                    inc.started = 1'b1;
                end
            EV_DL_OK:
                if (cur_state == ST_DOWNLOAD)
                begin
                    ok = 1'b1;
                    nxt = ST_VERIFY;
                end
            EV_DL_FAIL:
                if (cur_state == ST_DOWNLOAD)
                begin
                    ok = 1'b1;
                    nxt = ST_FAILED;
                end
            EV_VER_OK:
                if (cur_state == ST_VERIFY)
                begin
                    ok = 1'b1;
                    nxt = ST_STAGE;
                end
            EV_VER_FAIL:
                if (cur_state == ST_VERIFY)
                begin
                    ok = 1'b1;
                    nxt = ST_FAILED;
                    inc.verify_fail = 1'b1;
                end
            EV_STAGE_OK:
                if (cur_state == ST_STAGE)
                begin
                    ok = 1'b1;
                    nxt = ST_PREFLIGHT;
                end
            EV_PRE_OK:
                if (cur_state == ST_PREFLIGHT)
                begin
                    ok = 1'b1;
                    nxt = ST_ACTIVATE;
                end
            EV_PRE_FAIL:
                if (cur_state == ST_PREFLIGHT)
                begin
                    ok = 1'b1;
                    nxt = ST_FAILED;
                end
            EV_ACT_OK:
                if (cur_state == ST_ACTIVATE)
                begin
                    ok = 1'b1;
                    if (hooks.activate && hook_failed)
                    begin
                        hf = 1'b1;
                        nxt = ST_ROLLBACK;
                    end
                    else
                    begin
                        nxt = ST_HEALTH;
                    end
                end
            EV_ACT_FAIL:
                if (cur_state == ST_ACTIVATE)
                begin
                    ok = 1'b1;
                    nxt = ST_ROLLBACK;
                end
            EV_HL_OK:
                if (cur_state == ST_HEALTH)
                begin
                    ok = 1'b1;
                    nxt = ST_COMMIT;
                end
            EV_HL_FAIL:
                if (cur_state == ST_HEALTH)
                begin
                    ok = 1'b1;
                    nxt = ST_ROLLBACK;
                    inc.health_fail = 1'b1;
                end
            EV_COMMIT_OK:
                if (cur_state == ST_COMMIT)
                begin
                    ok = 1'b1;
                    if (hooks.commit && hook_failed)
                    begin
                        hf = 1'b1;
                        nxt = ST_FAILED;
                    end
                    else
                    begin
                        nxt = ST_DONE;
                        inc.committed = 1'b1;
                    end
                end
            EV_RB_DONE:
                if (cur_state == ST_ROLLBACK)
                begin
                    // A failing rollback hook still ends in failed, but is not counted as a rollback.
                    ok = 1'b1;
                    nxt = ST_FAILED;
                    if (hooks.rollback && hook_failed)
                    begin
                        hf = 1'b1;
                    end
                    else
                    begin
                        inc.rollback = 1'b1;
                    end
                end
            EV_CANCEL:
                if (cur_state == ST_DOWNLOAD || cur_state == ST_VERIFY ||
                    cur_state == ST_STAGE || cur_state == ST_PREFLIGHT)
                begin
                    ok = 1'b1;
                    nxt = ST_IDLE;
                    inc.cancel = 1'b1;
                end
            default:
                ok = 1'b0;
        endcase

        inc.seq      = ok;
        inc.rejected = !ok;

        step.next_state = nxt;
        step.inc        = inc;
        if (!ok)
        begin
            step.status = STATUS_REJECTED;
        end
        else if (hf)
        begin
            step.status = STATUS_HOOKFAIL;
        end
        else
        begin
            step.status = STATUS_OK;
        end
    end
endmodule

### rtl/core/ulf_track.sv
// Lifecycle state and statistics counters, updated once per processed event.
// Depends on ulf_pkg.
module ulf_track (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            update,
    input  ulf_pkg::step_t  step,
    output ulf_pkg::snap_t  snap
);
    import ulf_pkg::*;

    snap_t snap_reg;
    snap_t snap_next;

    always_comb
    begin
        snap_next = snap_reg;
        if (update)
        begin
            snap_next.cur_state   = step.next_state;
            snap_next.seq         = snap_reg.seq         + {31'd0, step.inc.seq};
            snap_next.started     = snap_reg.started     + {31'd0, step.inc.started};
            snap_next.committed   = snap_reg.committed   + {31'd0, step.inc.committed};
            snap_next.rollback    = snap_reg.rollback    + {31'd0, step.inc.rollback};
            snap_next.verify_fail = snap_reg.verify_fail + {31'd0, step.inc.verify_fail};
            snap_next.health_fail = snap_reg.health_fail + {31'd0, step.inc.health_fail};
            snap_next.rejected    = snap_reg.rejected    + {31'd0, step.inc.rejected};
            snap_next.cancel      = snap_reg.cancel      + {31'd0, step.inc.cancel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_reg <= '0;
        end
        else
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap = snap_reg;
endmodule

### rtl/core/update_lifecycle_fsm.sv
// Top level of the update lifecycle sequencer.
// Depends on ulf_pkg, ulf_evt_if, ulf_res_if, ulf_apb, ulf_step, ulf_track.
//
// Usage:
//   Events arrive on the evt channel (event_code, hook_failed) with a
//   valid/ready handshake; each request yields exactly one result on the res
//   channel: status, the state after the event and the eight counters.
//   The hook enables are set through the APB port (byte addresses 0, 4, 8;
//   bit 0 is the enable) while no request is in flight.
//   From request acceptance to result valid, the request sits in the input
//   register, then the transition logic writes the state and counter
//   registers, which double as the result register. Throughput is one
//   event per cycle while the receiver does not stall; the state register
//   loop is one level of transition logic plus a 32-bit increment.
//   Reset clears the state to idle, all counters and the hook enables.
//   When the receiver stalls, the result holds and the input register takes
//   one more request; further requests see ready low until the result goes.
module update_lifecycle_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    ulf_evt_if.sink                     evt,
    ulf_res_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ulf_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ulf_pkg::*;

    hook_cfg_t hooks;
    step_t     step;
    snap_t     snap;

    logic      in_vld_reg;
    logic      in_vld_next;
    evt_code_t ev_reg;
    logic      hf_reg;
    logic      res_vld_reg;
    logic      res_vld_next;
    status_t   status_reg;
    logic      adv;
    logic      take;

    // The queued event moves on whenever the result slot is free or emptying.
    assign adv       = in_vld_reg && (!res_vld_reg || res.ready);
    assign evt.ready = !in_vld_reg || adv;
    assign take      = evt.valid && evt.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
        begin
            in_vld_next = 1'b1;
        end
        else if (adv)
        begin
            in_vld_next = 1'b0;
        end

        res_vld_next = res_vld_reg;
        if (adv)
        begin
            res_vld_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ev_reg <= evt.event_code;
            hf_reg <= evt.hook_failed;
        end
        if (adv)
        begin
            status_reg <= step.status;
        end
    end

    ulf_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .hooks   (hooks)
    );

    ulf_step u_step (
        .cur_state   (snap.cur_state),
        .event_code  (ev_reg),
        .hook_failed (hf_reg),
        .hooks       (hooks),
        .step        (step)
    );

    ulf_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (adv),
        .step   (step),
        .snap   (snap)
    );

    assign res.valid             = res_vld_reg;
    assign res.status            = status_reg;
    assign res.cur_state         = snap.cur_state;
    assign res.seq_count         = snap.seq;
    assign res.started_count     = snap.started;
    assign res.committed_count   = snap.committed;
    assign res.rollback_count    = snap.rollback;
    assign res.verify_fail_count = snap.verify_fail;
    assign res.health_fail_count = snap.health_fail;
    assign res.rejected_count    = snap.rejected;
    assign res.cancel_count      = snap.cancel;

`include "update_lifecycle_fsm_assert.svh"

    `ULF_ASSERT_NEXT(a_reject_holds_seq, adv && step.status == STATUS_REJECTED,
        snap.seq == $past(snap.seq))
    `ULF_ASSERT_NEXT(a_reject_counted, adv && step.status == STATUS_REJECTED,
        snap.rejected == $past(snap.rejected) + 32'd1)
    `ULF_ASSERT_SAME(a_hookfail_state, res_vld_reg && status_reg == STATUS_HOOKFAIL,
        snap.cur_state == ST_ROLLBACK || snap.cur_state == ST_FAILED)
    `ULF_ASSERT_NEXT(a_queued_kept, in_vld_reg && !adv, in_vld_reg)

endmodule
